// ===== hw/rtl/mephm_pkg.sv =====
// ----------------------------------------------------------------------------
// mephm_pkg: shared types and constants for the ellipse hit-mask block
// Register map, field widths and the pipeline control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package mephm_pkg;
    localparam int MaxEllipses = 4;
    localparam int CoordW = 12;
    localparam int SqW = 25;     // dx*dx + dy*dy, dx up to 4095 in magnitude
    localparam int RootW = 13;   // isqrt of a 25-bit value
    localparam int RootSteps = 13;
    localparam int AddrW = 6;

    localparam logic [AddrW-1:0] AddrCount = 6'h00;
    localparam logic [AddrW-1:0] AddrEllA = 6'h08;
    localparam logic [AddrW-1:0] AddrEllB = 6'h10;
    localparam logic [AddrW-1:0] AddrEllC = 6'h18;
    localparam logic [AddrW-1:0] AddrEllD = 6'h20;

    typedef struct packed {
        logic       valid;
        logic [2:0] active;
    } t_ctrl;
endpackage
`default_nettype wire

// ===== hw/rtl/mephm_sqrt.sv =====
// ----------------------------------------------------------------------------
// mephm_sqrt: pipelined floor square root
// One result bit per stage; advances only when the enable is high.
// ----------------------------------------------------------------------------
`default_nettype none
module mephm_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [mephm_pkg::SqW-1:0]     i_sq,
    output logic      [mephm_pkg::RootW-1:0]   o_root
);
    localparam int N = mephm_pkg::RootSteps;
    localparam int RW = 2 * N;

    logic [RW-1:0] r_rem [N];
    logic [N-1:0]  r_res [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < N; s++) begin
                logic [RW-1:0] rem;
                logic [N-1:0]  res;
                logic [RW-1:0] trial;
                rem = (s == 0) ? RW'(i_sq) : r_rem[s-1];
                res = (s == 0) ? '0 : r_res[s-1];
                trial = RW'({res, 2'b01}) << (2 * (N - 1 - s));
                if (rem >= trial) begin
                    r_rem[s] <= rem - trial;
                    r_res[s] <= {res[N-2:0], 1'b1};
                end else begin
                    r_rem[s] <= rem;
                    r_res[s] <= {res[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_res[N-1];
endmodule
`default_nettype wire

// ===== hw/rtl/mephm_unit.sv =====
// ----------------------------------------------------------------------------
// mephm_unit: one ellipse test
// Squares distances, takes three square roots, then compares the sum of two roots with the scaled third root.
// ----------------------------------------------------------------------------
`default_nettype none
module mephm_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [mephm_pkg::CoordW-1:0] i_px,
    input  wire logic signed [mephm_pkg::CoordW-1:0] i_py,
    input  wire logic [63:0]                       i_ell,
    output logic                                   o_hit
);
    localparam int N = mephm_pkg::RootSteps;
    logic signed [12:0] dx1, dy1, dx2, dy2, dxf, dyf;
    logic [mephm_pkg::SqW-1:0] r_sq1, r_sq2, r_sqf;
    logic [mephm_pkg::RootW-1:0] d1, d2, df;
    logic [15:0] r_mult [N+1];
    logic [13:0] r_sum;
    logic [12:0] r_df;
    logic [15:0] r_m2;
    logic [28:0] r_prod;
    logic [25:0] r_lhs;
    logic r_hit;

    assign dx1 = 13'(i_px) - 13'($signed(i_ell[11:0]));
    assign dy1 = 13'(i_py) - 13'($signed(i_ell[23:12]));
    assign dx2 = 13'(i_px) - 13'($signed(i_ell[35:24]));
    assign dy2 = 13'(i_py) - 13'($signed(i_ell[47:36]));
    assign dxf = 13'($signed(i_ell[11:0])) - 13'($signed(i_ell[35:24]));
    assign dyf = 13'($signed(i_ell[23:12])) - 13'($signed(i_ell[47:36]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq1 <= 25'($unsigned(26'(dx1) * 26'(dx1)))
                     + 25'($unsigned(26'(dy1) * 26'(dy1)));
            r_sq2 <= 25'($unsigned(26'(dx2) * 26'(dx2)))
                     + 25'($unsigned(26'(dy2) * 26'(dy2)));
            r_sqf <= 25'($unsigned(26'(dxf) * 26'(dxf)))
                     + 25'($unsigned(26'(dyf) * 26'(dyf)));
            r_mult[0] <= i_ell[63:48];
            for (int s = 1; s <= N; s++) r_mult[s] <= r_mult[s-1];
            r_sum <= 14'(d1) + 14'(d2);
            r_df <= df;
            r_m2 <= r_mult[N];
            r_prod <= 29'(r_df) * 29'(r_m2);
            r_lhs <= {r_sum, 12'b0};
            r_hit <= 29'(r_lhs) <= r_prod;
        end
    end

    mephm_sqrt u_s1 (.i_clk(i_clk), .i_en(i_en), .i_sq(r_sq1), .o_root(d1));
    mephm_sqrt u_s2 (.i_clk(i_clk), .i_en(i_en), .i_sq(r_sq2), .o_root(d2));
    mephm_sqrt u_sf (.i_clk(i_clk), .i_en(i_en), .i_sq(r_sqf), .o_root(df));

    assign o_hit = r_hit;
endmodule
`default_nettype wire

// ===== hw/rtl/multi_ellipse_point_hit_mask.sv =====
// ----------------------------------------------------------------------------
// multi_ellipse_point_hit_mask: point test against four ellipses
// Top level with APB register file, pipeline control and output stage.
// ----------------------------------------------------------------------------
// Accepts one point per cycle while the pipeline advances and returns its hit
// mask; the squares are registered at the accepting edge, followed by the
// 13-stage square-root pipelines and the sum, multiply, compare and output
// stages. The whole pipeline advances when the output register is empty or
// being taken, so a stall holds every stage in place.
// Registers sit at byte addresses 0x00 (count) and 0x08..0x20 (ellipses).
`default_nettype none
module multi_ellipse_point_hit_mask (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic signed [11:0] i_point_x,
    input  wire logic signed [11:0] i_point_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [3:0]  o_hit_mask,
    output logic             o_any_hit
);
    localparam int Lat = mephm_pkg::RootSteps + 4;
    localparam int NE = mephm_pkg::MaxEllipses;

    logic [2:0]  r_count;
    logic [63:0] r_ell [NE];
    mephm_pkg::t_ctrl r_ctrl [Lat];
    logic        en;
    logic [NE-1:0] hits;
    logic [2:0]  act;
    logic [NE-1:0] mask;
    logic        r_ovalid;
    logic [3:0]  r_mask;

    assign pready = 1'b1;
    assign en = !r_ovalid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < NE; k++) r_ell[k] <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                mephm_pkg::AddrCount: r_count <= pwdata[2:0];
                mephm_pkg::AddrEllA:  r_ell[0] <= pwdata;
                mephm_pkg::AddrEllB:  r_ell[1] <= pwdata;
                mephm_pkg::AddrEllC:  r_ell[2] <= pwdata;
                mephm_pkg::AddrEllD:  r_ell[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            mephm_pkg::AddrCount: prdata = {61'b0, r_count};
            mephm_pkg::AddrEllA:  prdata = r_ell[0];
            mephm_pkg::AddrEllB:  prdata = r_ell[1];
            mephm_pkg::AddrEllC:  prdata = r_ell[2];
            mephm_pkg::AddrEllD:  prdata = r_ell[3];
            default:              prdata = '0;
        endcase
    end

    for (genvar k = 0; k < NE; k++) begin : g_unit
        mephm_unit u_unit (
            .i_clk(i_clk), .i_en(en), .i_px(i_point_x), .i_py(i_point_y),
            .i_ell(r_ell[k]), .o_hit(hits[k])
        );
    end

    assign act = (r_count > 3'(NE)) ? 3'(NE) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Lat; s++) r_ctrl[s] <= '0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ctrl[0] <= '{valid: i_valid, active: act};
            for (int s = 1; s < Lat; s++) r_ctrl[s] <= r_ctrl[s-1];
            r_ovalid <= r_ctrl[Lat-1].valid;
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++)
            mask[k] = hits[k] && (3'(k) < r_ctrl[Lat-1].active);
    end

    always_ff @(posedge i_clk) begin
        if (en) r_mask <= 4'(mask);
    end

    assign o_valid = r_ovalid;
    assign o_hit_mask = r_mask;
    assign o_any_hit = |r_mask;
endmodule
`default_nettype wire
